FILE: hw/rtl/hltl_pkg.sv
// Package for the handheld timer and display timing block.
// Holds the shared types, timing constants and register index codes.
// No dependencies.
`default_nettype none

package hltl_pkg;

  // Width of the shared add and reduce datapath. It holds the timer
  // accumulator plus one step.
  localparam int unsigned AccWidth = 9;

  localparam logic [3:0]          MaxStepCycles = 4'd15;
  localparam logic [AccWidth-1:0] DivPeriod     = 9'd64;
  localparam logic [AccWidth-1:0] LinePeriod    = 9'd114;
  localparam logic [AccWidth-1:0] OamStart      = 9'd51;
  localparam logic [AccWidth-1:0] XferStart     = 9'd71;
  localparam logic [7:0]          VblankLine    = 8'd144;
  localparam logic [7:0]          LastLine      = 8'd153;

  typedef enum logic [1:0] {
    MODE_HBLANK = 2'd0,
    MODE_VBLANK = 2'd1,
    MODE_OAM    = 2'd2,
    MODE_XFER   = 2'd3
  } lcd_mode_e;

  typedef enum logic [2:0] {
    CFG_TIMER_ENABLE   = 3'd0,
    CFG_CLOCK_SELECT   = 3'd1,
    CFG_RELOAD_VALUE   = 3'd2,
    CFG_LINE_COMPARE   = 3'd3,
    CFG_STAT_IRQ_EN    = 3'd4,
    CFG_DISPLAY_ENABLE = 3'd5,
    CFG_HDMA_ENABLE    = 3'd6,
    CFG_UNUSED         = 3'd7
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE      = 3'd0,
    ST_DIV       = 3'd1,
    ST_LCD       = 3'd2,
    ST_TMR_FIRST = 3'd3,
    ST_TMR_LOOP  = 3'd4,
    ST_FINISH    = 3'd5
  } seq_state_e;

  // Scanline timing state.
  typedef struct packed {
    logic [6:0] line_cycles;
    logic       line_drawn;
    logic [7:0] line;
    lcd_mode_e  mode;
    logic       coincidence;
  } lcd_state_t;

  // Event flags produced by one display step.
  typedef struct packed {
    logic       vblank_irq;
    logic       stat_irq;
    logic       draw_request;
    logic [7:0] draw_row;
    logic       hdma_request;
  } lcd_flags_t;

  // Display settings seen by the scanline step.
  typedef struct packed {
    logic [7:0] line_compare;
    logic [3:0] stat_irq_enables;
    logic       hdma_enable;
  } lcd_cfg_t;

  // Result of the shared add and reduce unit.
  typedef struct packed {
    logic [AccWidth-1:0] sum;
    logic                ge;
    logic [AccWidth-1:0] rem;
  } acc_res_t;

  function automatic logic [AccWidth-1:0] tick_period(input logic [1:0] sel);
    logic [AccWidth-1:0] p;
    case (sel)
      2'd0:    p = 9'd256;
      2'd1:    p = 9'd4;
      2'd2:    p = 9'd16;
      default: p = 9'd64;
    endcase
    return p;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/hltl_acc_unit.sv
// Shared add, compare and subtract unit of the timer and display block.
// Depends on hltl_pkg.
`default_nettype none

module hltl_acc_unit (
  input  wire logic [hltl_pkg::AccWidth-1:0] base_i,
  input  wire logic [3:0]                    addend_i,
  input  wire logic [hltl_pkg::AccWidth-1:0] modulus_i,
  output hltl_pkg::acc_res_t                 res_o
);

  logic [hltl_pkg::AccWidth-1:0] sum;

  assign sum        = base_i + {{(hltl_pkg::AccWidth-4){1'b0}}, addend_i};
  assign res_o.sum  = sum;
  assign res_o.ge   = (sum >= modulus_i);
  assign res_o.rem  = sum - modulus_i;

endmodule

`default_nettype wire

FILE: hw/rtl/hltl_lcd_step.sv
// Next scanline state and event flags for one display step.
// Takes the shared unit's reduced line position. Depends on hltl_pkg.
`default_nettype none

module hltl_lcd_step (
  input  hltl_pkg::lcd_state_t cur_i,
  input  hltl_pkg::acc_res_t   acc_i,
  input  hltl_pkg::lcd_cfg_t   cfg_i,
  output hltl_pkg::lcd_state_t nxt_o,
  output hltl_pkg::lcd_flags_t flags_o
);

  logic [7:0] next_line;

  assign next_line = (cur_i.line >= hltl_pkg::LastLine) ? 8'd0 : cur_i.line + 8'd1;

  always_comb begin
    nxt_o   = cur_i;
    flags_o = '0;

    // The mode is sampled from the position before the line advance.
    if (cur_i.line >= hltl_pkg::VblankLine) begin
      nxt_o.mode = hltl_pkg::MODE_VBLANK;
    end else if (acc_i.sum < hltl_pkg::OamStart) begin
      nxt_o.mode       = hltl_pkg::MODE_HBLANK;
      nxt_o.line_drawn = 1'b0;
    end else if (acc_i.sum < hltl_pkg::XferStart) begin
      nxt_o.mode = hltl_pkg::MODE_OAM;
    end else begin
      nxt_o.mode = hltl_pkg::MODE_XFER;
      if (!cur_i.line_drawn) begin
        flags_o.draw_request = 1'b1;
        flags_o.draw_row     = cur_i.line;
        nxt_o.line_drawn     = 1'b1;
      end
    end

    if (acc_i.ge) begin
      nxt_o.line_cycles    = acc_i.rem[6:0];
      nxt_o.line           = next_line;
      flags_o.hdma_request = cfg_i.hdma_enable;
      if (next_line == hltl_pkg::VblankLine) begin
        nxt_o.mode         = hltl_pkg::MODE_VBLANK;
        flags_o.vblank_irq = 1'b1;
      end
      nxt_o.coincidence = (next_line == cfg_i.line_compare);
      if ((next_line == cfg_i.line_compare) && cfg_i.stat_irq_enables[3]) begin
        flags_o.stat_irq = 1'b1;
      end
    end else begin
      nxt_o.line_cycles = acc_i.sum[6:0];
    end

    if ((cfg_i.stat_irq_enables[2] && (nxt_o.mode == hltl_pkg::MODE_OAM)) ||
        (cfg_i.stat_irq_enables[1] && (nxt_o.mode == hltl_pkg::MODE_VBLANK)) ||
        (cfg_i.stat_irq_enables[0] && acc_i.ge)) begin
      flags_o.stat_irq = 1'b1;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/handheld_timer_and_lcd_timing.sv
// Handheld timer and display timing block, top level.
// A word is accepted only while the sequencer is idle, so the next word waits
// until the last one has been handed to the result register. With the timer
// on, the counter loop makes a further pass through the shared add unit for
// each counter tick, and a stalled result holds off the next word. Reset is
// asynchronous and active low; it clears all but the output data registers.
`default_nettype none

module handheld_timer_and_lcd_timing (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  // Configuration write port.
  input  wire logic       cfg_we_i,
  input  wire logic [2:0] cfg_idx_i,
  input  wire logic [7:0] cfg_wdata_i,
  // Input channel.
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [3:0] elapsed_cycles_i,
  // Output channel.
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [7:0]      divider_value_o,
  output logic [7:0]      counter_value_o,
  output logic [7:0]      current_line_o,
  output logic [1:0]      lcd_mode_o,
  output logic            coincidence_o,
  output logic            vblank_irq_o,
  output logic            stat_irq_o,
  output logic            timer_irq_o,
  output logic            draw_request_o,
  output logic [7:0]      draw_line_number_o,
  output logic            hdma_request_o
);

  // The sequencer walks each word through the divider, the display timing
  // and, with the timer on, the programmable counter, using one shared add,
  // compare and subtract unit for all three. The counter gets one tick per
  // cycle, so a period change leaving a large accumulator costs more passes.

  // Configuration registers.
  logic       timer_enable_q;
  logic [1:0] clock_select_q;
  logic [7:0] reload_value_q;
  hltl_pkg::lcd_cfg_t lcd_cfg_q;
  logic       display_enable_q;

  // Timing state.
  logic [5:0]              div_accum_q;
  logic [7:0]              div_reg_q;
  hltl_pkg::lcd_state_t    lcd_q;
  logic [hltl_pkg::AccWidth-1:0] timer_accum_q;
  logic [7:0]              counter_q;

  // Per-word working registers.
  hltl_pkg::seq_state_e    state_q, state_d;
  logic [3:0]              el_q;
  hltl_pkg::lcd_flags_t    flags_q;
  logic                    timer_irq_q;

  // Result register.
  logic out_valid_q;

  // Shared unit operands.
  logic [hltl_pkg::AccWidth-1:0] unit_base, unit_mod;
  logic [3:0]                    unit_addend;
  hltl_pkg::acc_res_t            unit_res;

  hltl_pkg::lcd_state_t lcd_nxt;
  hltl_pkg::lcd_flags_t lcd_flags;

  logic accept_in, load_out;

  assign in_stall_o  = (state_q != hltl_pkg::ST_IDLE);
  assign accept_in   = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;

  // Configuration writes; index seven is ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timer_enable_q   <= 1'b0;
      clock_select_q   <= 2'd0;
      reload_value_q   <= 8'd0;
      lcd_cfg_q        <= '0;
      display_enable_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        hltl_pkg::CFG_TIMER_ENABLE:   timer_enable_q             <= cfg_wdata_i[0];
        hltl_pkg::CFG_CLOCK_SELECT:   clock_select_q             <= cfg_wdata_i[1:0];
        hltl_pkg::CFG_RELOAD_VALUE:   reload_value_q             <= cfg_wdata_i;
        hltl_pkg::CFG_LINE_COMPARE:   lcd_cfg_q.line_compare     <= cfg_wdata_i;
        hltl_pkg::CFG_STAT_IRQ_EN:    lcd_cfg_q.stat_irq_enables <= cfg_wdata_i[3:0];
        hltl_pkg::CFG_DISPLAY_ENABLE: display_enable_q           <= cfg_wdata_i[0];
        hltl_pkg::CFG_HDMA_ENABLE:    lcd_cfg_q.hdma_enable      <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // Operand selection for the shared unit. The counter loop adds the step
  // only on its first pass and then keeps reducing by the period.
  always_comb begin
    unit_base   = '0;
    unit_addend = 4'd0;
    unit_mod    = '0;
    case (state_q)
      hltl_pkg::ST_DIV: begin
        unit_base   = {{(hltl_pkg::AccWidth-6){1'b0}}, div_accum_q};
        unit_addend = el_q;
        unit_mod    = hltl_pkg::DivPeriod;
      end
      hltl_pkg::ST_LCD: begin
        unit_base   = {{(hltl_pkg::AccWidth-7){1'b0}}, lcd_q.line_cycles};
        unit_addend = el_q;
        unit_mod    = hltl_pkg::LinePeriod;
      end
      hltl_pkg::ST_TMR_FIRST: begin
        unit_base   = timer_accum_q;
        unit_addend = el_q;
        unit_mod    = hltl_pkg::tick_period(clock_select_q);
      end
      hltl_pkg::ST_TMR_LOOP: begin
        unit_base   = timer_accum_q;
        unit_mod    = hltl_pkg::tick_period(clock_select_q);
      end
      default: ;
    endcase
  end

  hltl_acc_unit u_acc (
    .base_i    (unit_base),
    .addend_i  (unit_addend),
    .modulus_i (unit_mod),
    .res_o     (unit_res)
  );

  hltl_lcd_step u_lcd (
    .cur_i   (lcd_q),
    .acc_i   (unit_res),
    .cfg_i   (lcd_cfg_q),
    .nxt_o   (lcd_nxt),
    .flags_o (lcd_flags)
  );

  // Sequencer next state.
  always_comb begin
    state_d  = state_q;
    load_out = 1'b0;
    case (state_q)
      hltl_pkg::ST_IDLE: begin
        if (accept_in) begin
          state_d = hltl_pkg::ST_DIV;
        end
      end
      hltl_pkg::ST_DIV: begin
        state_d = hltl_pkg::ST_LCD;
      end
      hltl_pkg::ST_LCD: begin
        state_d = timer_enable_q ? hltl_pkg::ST_TMR_FIRST : hltl_pkg::ST_FINISH;
      end
      hltl_pkg::ST_TMR_FIRST, hltl_pkg::ST_TMR_LOOP: begin
        state_d = unit_res.ge ? hltl_pkg::ST_TMR_LOOP : hltl_pkg::ST_FINISH;
      end
      hltl_pkg::ST_FINISH: begin
        // Hand over once the result register is free or being emptied.
        if (!out_valid_q || !out_stall_i) begin
          load_out = 1'b1;
          state_d  = hltl_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = hltl_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= hltl_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Timing state and per-word flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      el_q          <= 4'd0;
      div_accum_q   <= 6'd0;
      div_reg_q     <= 8'd0;
      lcd_q         <= '0;
      timer_accum_q <= '0;
      counter_q     <= 8'd0;
      flags_q       <= '0;
      timer_irq_q   <= 1'b0;
    end else begin
      case (state_q)
        hltl_pkg::ST_IDLE: begin
          if (accept_in) begin
            el_q        <= (elapsed_cycles_i > hltl_pkg::MaxStepCycles) ?
                           hltl_pkg::MaxStepCycles : elapsed_cycles_i;
            flags_q     <= '0;
            timer_irq_q <= 1'b0;
          end
        end
        hltl_pkg::ST_DIV: begin
          // A step is clamped to MaxStepCycles, so it wraps the divider at most once.
          if (unit_res.ge) begin
            div_accum_q <= unit_res.rem[5:0];
            div_reg_q   <= div_reg_q + 8'd1;
          end else begin
            div_accum_q <= unit_res.sum[5:0];
          end
        end
        hltl_pkg::ST_LCD: begin
          if (display_enable_q) begin
            lcd_q   <= lcd_nxt;
            flags_q <= lcd_flags;
          end
        end
        hltl_pkg::ST_TMR_FIRST, hltl_pkg::ST_TMR_LOOP: begin
          if (unit_res.ge) begin
            timer_accum_q <= unit_res.rem;
            if (counter_q == 8'hFF) begin
              counter_q   <= reload_value_q;
              timer_irq_q <= 1'b1;
            end else begin
              counter_q <= counter_q + 8'd1;
            end
          end else begin
            timer_accum_q <= unit_res.sum;
          end
        end
        default: ;
      endcase
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      divider_value_o    <= div_reg_q;
      counter_value_o    <= counter_q;
      current_line_o     <= lcd_q.line;
      lcd_mode_o         <= lcd_q.mode;
      coincidence_o      <= lcd_q.coincidence;
      vblank_irq_o       <= flags_q.vblank_irq;
      stat_irq_o         <= flags_q.stat_irq;
      timer_irq_o        <= timer_irq_q;
      draw_request_o     <= flags_q.draw_request;
      draw_line_number_o <= flags_q.draw_row;
      hdma_request_o     <= flags_q.hdma_request;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/hltl_checker.sv
// Port-level checks for the handheld timer and display timing block.
// Bound to the top level below. Depends on hltl_pkg.
`default_nettype none

module hltl_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       out_valid_o,
  input wire logic       out_stall_i,
  input wire logic [7:0] current_line_o,
  input wire logic [1:0] lcd_mode_o,
  input wire logic       vblank_irq_o,
  input wire logic       draw_request_o,
  input wire logic [7:0] draw_line_number_o
);

  // A stalled word stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result word withdrawn while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> current_line_o <= hltl_pkg::LastLine)
    else $error("scanline beyond last line");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (current_line_o >= hltl_pkg::VblankLine) |->
      lcd_mode_o == hltl_pkg::MODE_VBLANK)
    else $error("vblank line without vblank mode");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && vblank_irq_o |-> current_line_o == hltl_pkg::VblankLine)
    else $error("vblank interrupt away from first vblank line");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !draw_request_o |-> draw_line_number_o == 8'd0)
    else $error("draw line number set without draw request");

endmodule

bind handheld_timer_and_lcd_timing hltl_checker u_hltl_checker (.*);

`default_nettype wire
